[hw/rtl/obmc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package obmc_pkg;

  // Fixed field widths of the item channels.
  localparam int CMD_W    = 3;
  localparam int TGT_W    = 8;
  localparam int PC_OUT_W = 8;
  localparam int ACT_W    = 3;

  // Commands carried by an input item.
  localparam logic [CMD_W-1:0] CMD_RESTART   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_APP_LOAD  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_APP_STORE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_APP_JUMP  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_EXECUTE   = 3'd4;

  // Actions reported by a result item.
  localparam logic [ACT_W-1:0] ACT_RESTART = 3'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_LOAD    = 3'd2;
  localparam logic [ACT_W-1:0] ACT_STORE   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_JUMP    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_SKIP    = 3'd5;

  // Restart position of the program counter and the special cells.
  localparam int START_POS   = 6;
  localparam int CELL_ZERO   = 0;
  localparam int CELL_ONE    = 1;
  localparam int CELL_NOT    = 2;
  localparam int CELL_OR     = 3;
  localparam int CELL_AND    = 4;
  localparam int CELL_SHARED = 5;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_APPEND,
    ST_FETCH,
    ST_EXEC,
    ST_LOAD,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/obmc_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface obmc_in_if import obmc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [TGT_W-1:0] target_address;

  modport source (output valid, output command, output target_address, input ready);
  modport sink (input valid, input command, input target_address, output ready);
endinterface

interface obmc_out_if import obmc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [PC_OUT_W-1:0] program_counter;
  logic                accumulator;
  logic [ACT_W-1:0]    action;
  logic [TGT_W-1:0]    operand_address;

  modport source (output valid, output program_counter, output accumulator,
                  output action, output operand_address, input ready);
  modport sink (input valid, input program_counter, input accumulator,
                input action, input operand_address, output ready);
endinterface

`default_nettype wire

[hw/rtl/one_bit_memory_mapped_cpu.sv]
// Restart goes straight to the result item; append writes the N instruction bits, and
// execute fetches them and then executes (a load also reads its operand) before the
// result item, where N is the instruction length in bits (ADDRESS_BITS+1 for a jump,
// ADDRESS_BITS+2 otherwise); the one-bit store port moves one instruction bit per cycle.
// Items are taken one at a time; the next is accepted once the result is loaded.
// Reset is synchronous, active low; a clearing pass over every store cell follows.
`timescale 1ns / 1ps
`default_nettype none

module one_bit_memory_mapped_cpu import obmc_pkg::*; #(
  parameter int ADDRESS_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  obmc_in_if.sink   in_chan,
  obmc_out_if.source out_chan
);

  localparam int AW    = ADDRESS_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int SR_W  = AW + 2;
  localparam int CNT_W = $clog2(AW + 3);

  // Instruction lengths in bits: a jump has one opcode bit, load and store two.
  localparam logic [CNT_W-1:0] LEN_JUMP = CNT_W'(AW + 1);
  localparam logic [CNT_W-1:0] LEN_DATA = CNT_W'(AW + 2);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  localparam logic [AW-1:0] ADDR_START  = AW'(START_POS);
  localparam logic [AW-1:0] ADDR_ZERO   = AW'(CELL_ZERO);
  localparam logic [AW-1:0] ADDR_ONE    = AW'(CELL_ONE);
  localparam logic [AW-1:0] ADDR_NOT    = AW'(CELL_NOT);
  localparam logic [AW-1:0] ADDR_OR     = AW'(CELL_OR);
  localparam logic [AW-1:0] ADDR_AND    = AW'(CELL_AND);
  localparam logic [AW-1:0] ADDR_SHARED = AW'(CELL_SHARED);
  localparam logic [AW-1:0] ADDR_ONES   = '1;

  // Control state.
  state_t            state_r, state_nxt;
  logic [AW-1:0]     pc_r, pc_nxt;
  logic              acc_r, acc_nxt;
  logic              c5_r, c5_nxt;          // shadow of cell 5 for the OR and AND cells
  logic [AW-1:0]     clr_addr_r, clr_addr_nxt;
  logic              rvalid_r, rvalid_nxt;  // a fetch read was issued last cycle
  logic              out_valid_r, out_valid_nxt;

  // Datapath registers.
  logic [SR_W-1:0]   sr_r, sr_nxt;          // bits still to be appended, LSB first
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;        // append: bits left, fetch: reads issued
  logic [CNT_W-1:0]  proc_r, proc_nxt;      // fetch: bits received
  logic              op0_r, op0_nxt;
  logic              op1_r, op1_nxt;
  logic [AW-1:0]     addr_r, addr_nxt;      // operand address, shifted in LSB first
  logic [AW-1:0]     rd_addr_r;
  logic [ACT_W-1:0]  act_r, act_nxt;
  logic [AW-1:0]     opnd_r, opnd_nxt;
  logic [PC_OUT_W-1:0] out_pc_r;
  logic              out_acc_r;
  logic [ACT_W-1:0]  out_act_r;
  logic [TGT_W-1:0]  out_opnd_r;

  // Store port.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic              ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic              ram_rdata;

  logic [AW-1:0]     tgt;
  logic              rd_bit;
  logic [CNT_W-1:0]  need_len;
  logic              fetch_last;
  logic              out_load;

  obmc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign tgt = AW'(in_chan.target_address);

  // Reads of cells 0 to 4 are answered from constants, the accumulator and cell 5
  // instead of the store, whatever was written to those cells.
  always_comb begin
    unique case (rd_addr_r)
      ADDR_ZERO: rd_bit = 1'b0;
      ADDR_ONE:  rd_bit = 1'b1;
      ADDR_NOT:  rd_bit = ~acc_r;
      ADDR_OR:   rd_bit = acc_r | c5_r;
      ADDR_AND:  rd_bit = acc_r & c5_r;
      default:   rd_bit = ram_rdata;
    endcase
  end

  // Until the first opcode bit is known, assume the longer instruction. Reads are
  // issued on consecutive cycles, so the opcode is known long before the end.
  assign need_len   = (proc_r != '0 && op0_r) ? LEN_JUMP : LEN_DATA;
  assign fetch_last = rvalid_r && (proc_r == need_len - CNT_ONE);
  assign out_load   = (state_r == ST_FINISH) && (!out_valid_r || out_chan.ready);

  assign in_chan.ready            = (state_r == ST_IDLE);
  assign out_chan.valid           = out_valid_r;
  assign out_chan.program_counter = out_pc_r;
  assign out_chan.accumulator     = out_acc_r;
  assign out_chan.action          = out_act_r;
  assign out_chan.operand_address = out_opnd_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_ONES) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          unique case (in_chan.command) inside
            CMD_RESTART: state_nxt = ST_FINISH;
            CMD_APP_LOAD, CMD_APP_STORE, CMD_APP_JUMP: state_nxt = ST_APPEND;
            default: state_nxt = ST_FETCH;
          endcase
        end
      end
      ST_APPEND: begin
        if (cnt_r == CNT_ONE) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FETCH: begin
        if (fetch_last) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_nxt = (!op0_r && !op1_r) ? ST_LOAD : ST_FINISH;
      end
      ST_LOAD: begin
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and store port.
  always_comb begin
    pc_nxt       = pc_r;
    acc_nxt      = acc_r;
    c5_nxt       = c5_r;
    clr_addr_nxt = clr_addr_r;
    rvalid_nxt   = 1'b0;
    sr_nxt       = sr_r;
    cnt_nxt      = cnt_r;
    proc_nxt     = proc_r;
    op0_nxt      = op0_r;
    op1_nxt      = op1_r;
    addr_nxt     = addr_r;
    act_nxt      = act_r;
    opnd_nxt     = opnd_r;
    ram_we       = 1'b0;
    ram_waddr    = pc_r;
    ram_wdata    = 1'b0;
    ram_raddr    = pc_r;

    unique case (state_r)
      ST_CLEAR: begin
        ram_we       = 1'b1;
        ram_waddr    = clr_addr_r;
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (in_chan.valid) begin
          cnt_nxt  = '0;
          proc_nxt = '0;
          act_nxt  = ACT_APPEND;
          opnd_nxt = tgt;
          unique case (in_chan.command)
            CMD_RESTART: begin
              pc_nxt   = ADDR_START;
              act_nxt  = ACT_RESTART;
              opnd_nxt = '0;
            end
            CMD_APP_LOAD: begin
              sr_nxt  = {tgt, 1'b0, 1'b0};
              cnt_nxt = LEN_DATA;
            end
            CMD_APP_STORE: begin
              sr_nxt  = {tgt, 1'b1, 1'b0};
              cnt_nxt = LEN_DATA;
            end
            CMD_APP_JUMP: begin
              sr_nxt  = {1'b0, tgt, 1'b1};
              cnt_nxt = LEN_JUMP;
            end
            default: begin
              // Execute: the fetch counters start from zero.
            end
          endcase
        end
      end
      ST_APPEND: begin
        ram_we    = 1'b1;
        ram_wdata = sr_r[0];
        if (pc_r == ADDR_SHARED) begin
          c5_nxt = sr_r[0];
        end
        pc_nxt  = pc_r + AW'(1);
        sr_nxt  = sr_r >> 1;
        cnt_nxt = cnt_r - CNT_ONE;
      end
      ST_FETCH: begin
        if (cnt_r < need_len) begin
          pc_nxt     = pc_r + AW'(1);
          cnt_nxt    = cnt_r + CNT_ONE;
          rvalid_nxt = 1'b1;
        end
        if (rvalid_r) begin
          if (proc_r == '0) begin
            op0_nxt = rd_bit;
          end else if (proc_r == CNT_ONE && !op0_r) begin
            op1_nxt = rd_bit;
          end else begin
            addr_nxt = {rd_bit, addr_r[AW-1:1]};
          end
          proc_nxt = proc_r + CNT_ONE;
        end
      end
      ST_EXEC: begin
        opnd_nxt  = addr_r;
        ram_raddr = addr_r;
        if (op0_r) begin
          // A taken jump loads the target, a skipped one is already past it.
          act_nxt = acc_r ? ACT_JUMP : ACT_SKIP;
          if (acc_r) begin
            pc_nxt = addr_r;
          end
        end else if (op1_r) begin
          act_nxt   = ACT_STORE;
          ram_we    = 1'b1;
          ram_waddr = addr_r;
          ram_wdata = acc_r;
          if (addr_r == ADDR_SHARED) begin
            c5_nxt = acc_r;
          end
        end else begin
          act_nxt = ACT_LOAD;
        end
      end
      ST_LOAD: begin
        acc_nxt = rd_bit;
      end
      ST_FINISH: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      pc_r        <= ADDR_START;
      acc_r       <= 1'b0;
      c5_r        <= 1'b0;
      clr_addr_r  <= '0;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      acc_r       <= acc_nxt;
      c5_r        <= c5_nxt;
      clr_addr_r  <= clr_addr_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sr_r      <= sr_nxt;
    cnt_r     <= cnt_nxt;
    proc_r    <= proc_nxt;
    op0_r     <= op0_nxt;
    op1_r     <= op1_nxt;
    addr_r    <= addr_nxt;
    rd_addr_r <= ram_raddr;
    act_r     <= act_nxt;
    opnd_r    <= opnd_nxt;
    if (out_load) begin
      out_pc_r   <= PC_OUT_W'(pc_r);
      out_acc_r  <= acc_r;
      out_act_r  <= act_r;
      out_opnd_r <= TGT_W'(opnd_r);
    end
  end

endmodule

`default_nettype wire

[hw/rtl/obmc_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module obmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
